FILE: rtl/aenc_pkg.sv
// aenc_pkg: widths, command codes and state types shared by the arithmetic
// encoder core and its multiply-divide unit
// no dependencies
package aenc_pkg;

	localparam int FIELD_W  = 16;
	localparam int FOLLOW_W = 32;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DIV_HI = 7'b0000010,
		ST_DIV_LO = 7'b0000100,
		ST_UPDATE = 7'b0001000,
		ST_RENORM = 7'b0010000,
		ST_FINAL  = 7'b0100000,
		ST_FLUSH  = 7'b1000000
	} enc_state_t;

	typedef enum logic [2:0] {
		MD_IDLE = 3'b001,
		MD_MUL  = 3'b010,
		MD_DIV  = 3'b100
	} md_state_t;

endpackage

FILE: rtl/arithmetic_encoder_core.sv
// arithmetic_encoder_core: integer arithmetic encoder, interval narrowing and
// renormalisation with follow bit counting; depends on aenc_pkg, aenc_muldiv
//
// channel  direction  handshake           payload
// in       input      in_valid/in_stall   command, cum_low, cum_high, cum_total
// out      output     out_valid/out_stall out_bit, follow_count, last
//
// an encode item passes through the two divisions, the interval update, one
// renormalisation step per emitted or follow bit (at most CODE_BITS) and the
// closing check, then ST_FINAL passes on the last held bit if any; a flush uses ST_FLUSH
// a malformed symbol is dropped as it is accepted, an empty interval after the divisions
// is dropped too; reset restores the full interval and clears the follow count
// out_stall holds emission; in_stall is high while an item is in work
module arithmetic_encoder_core import aenc_pkg::*; #(
	parameter int CODE_BITS = 32,
	parameter int FREQ_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                command,
	input  logic [FIELD_W-1:0]  cum_low,
	input  logic [FIELD_W-1:0]  cum_high,
	input  logic [FIELD_W-1:0]  cum_total,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                out_bit,
	output logic [FOLLOW_W-1:0] follow_count,
	output logic                last
);

	localparam int CB = CODE_BITS;
	localparam int FB = FREQ_BITS;

	enc_state_t          state_q;
	logic [CB-1:0]       low_q;
	logic [CB-1:0]       high_q;
	logic [FOLLOW_W-1:0] pending_q;
	logic [FB-1:0]       cl_q;
	logic [FB-1:0]       ct_q;
	logic [CB:0]         hi_off_q;
	logic                held_valid_q;
	logic                held_bit_q;
	logic [FOLLOW_W-1:0] held_follow_q;
	logic                out_valid_q;
	logic                out_bit_q;
	logic [FOLLOW_W-1:0] out_follow_q;
	logic                out_last_q;

	logic [FB-1:0]       cl_in;
	logic [FB-1:0]       ch_in;
	logic [FB-1:0]       ct_in;
	logic                sym_ok;
	logic [CB:0]         range_val;
	logic                md_start;
	logic [FB-1:0]       md_factor;
	logic [FB-1:0]       md_divisor;
	logic                md_done;
	logic [CB:0]         md_quot;
	logic [CB:0]         high_sum;
	logic [CB:0]         low_sum;
	logic [FOLLOW_W-1:0] pend_inc;
	logic                out_free;
	logic                emit;
	logic                fol;
	logic                push;
	logic                push_bit;
	logic [FOLLOW_W-1:0] push_follow;
	logic                push_last;

	assign cl_in  = cum_low[FB-1:0];
	assign ch_in  = cum_high[FB-1:0];
	assign ct_in  = cum_total[FB-1:0];
	assign sym_ok = (ct_in != '0) && (cl_in < ch_in) && (ch_in <= ct_in);

	assign range_val  = {1'b0, high_q} - {1'b0, low_q} + 1'b1;
	assign md_start   = ((state_q == ST_IDLE) && in_valid && (command == CMD_ENCODE) && sym_ok)
		|| ((state_q == ST_DIV_HI) && md_done);
	assign md_factor  = (state_q == ST_IDLE) ? ch_in : cl_q;
	assign md_divisor = (state_q == ST_IDLE) ? ct_in : ct_q;

	aenc_muldiv #(
		.CODE_BITS (CODE_BITS),
		.FREQ_BITS (FREQ_BITS)
	) u_muldiv (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (md_start),
		.range_val (range_val),
		.factor    (md_factor),
		.divisor   (md_divisor),
		.done      (md_done),
		.quotient  (md_quot)
	);

	assign high_sum = {1'b0, low_q} + hi_off_q - 1'b1;
	assign low_sum  = {1'b0, low_q} + md_quot;
	assign pend_inc = (pending_q == '1) ? pending_q : pending_q + 1'b1;
	assign out_free = !out_valid_q || !out_stall;

	// emit when both ends share the top bit, follow when straddling the middle
	assign emit = !high_q[CB-1] || low_q[CB-1];
	assign fol  = (low_q[CB-1:CB-2] == 2'b01) && (high_q[CB-1:CB-2] == 2'b10);

	always_comb begin
		push        = 1'b0;
		push_bit    = held_bit_q;
		push_follow = held_follow_q;
		push_last   = 1'b1;
		unique case (state_q)
			ST_FLUSH: begin
				push        = out_free;
				push_bit    = low_q[CB-1] | low_q[CB-2];
				push_follow = pend_inc;
			end
			ST_RENORM: begin
				push      = emit && held_valid_q && out_free;
				push_last = 1'b0;
			end
			ST_FINAL: begin
				push = out_free;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			low_q         <= '0;
			high_q        <= '1;
			pending_q     <= '0;
			cl_q          <= '0;
			ct_q          <= '0;
			hi_off_q      <= '0;
			held_valid_q  <= 1'b0;
			held_bit_q    <= 1'b0;
			held_follow_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (command == CMD_FLUSH) begin
							state_q <= ST_FLUSH;
						end else if (sym_ok) begin
							cl_q    <= cl_in;
							ct_q    <= ct_in;
							state_q <= ST_DIV_HI;
						end
					end
				end
				ST_DIV_HI: begin
					if (md_done) begin
						hi_off_q <= md_quot;
						state_q  <= ST_DIV_LO;
					end
				end
				ST_DIV_LO: begin
					if (md_done) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					if (hi_off_q > md_quot) begin
						high_q       <= high_sum[CB-1:0];
						low_q        <= low_sum[CB-1:0];
						held_valid_q <= 1'b0;
						state_q      <= ST_RENORM;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_RENORM: begin
					priority if (emit) begin
						if (!held_valid_q || out_free) begin
							held_valid_q  <= 1'b1;
							held_bit_q    <= high_q[CB-1];
							held_follow_q <= pending_q;
							pending_q     <= '0;
							low_q         <= {low_q[CB-2:0], 1'b0};
							high_q        <= {high_q[CB-2:0], 1'b1};
						end
					end else if (fol) begin
						pending_q <= pend_inc;
						low_q     <= {~low_q[CB-2], low_q[CB-3:0], 1'b0};
						high_q    <= {~high_q[CB-2], high_q[CB-3:0], 1'b1};
					end else begin
						state_q <= held_valid_q ? ST_FINAL : ST_IDLE;
					end
				end
				ST_FINAL: begin
					if (out_free) begin
						held_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						pending_q <= '0;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_bit_q    <= 1'b0;
			out_follow_q <= '0;
			out_last_q   <= 1'b0;
		end else if (push) begin
			out_valid_q  <= 1'b1;
			out_bit_q    <= push_bit;
			out_follow_q <= push_follow;
			out_last_q   <= push_last;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign out_bit      = out_bit_q;
	assign follow_count = out_follow_q;
	assign last         = out_last_q;

endmodule

FILE: rtl/aenc_muldiv.sv
// aenc_muldiv: shared multiply then restoring divide, one quotient bit a cycle
// computes (range_val * factor) / divisor; depends on aenc_pkg
module aenc_muldiv import aenc_pkg::*; #(
	parameter int CODE_BITS = 32,
	parameter int FREQ_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [CODE_BITS:0]   range_val,
	input  logic [FREQ_BITS-1:0] factor,
	input  logic [FREQ_BITS-1:0] divisor,
	output logic                 done,
	output logic [CODE_BITS:0]   quotient
);

	localparam int QW    = CODE_BITS + 1;
	localparam int PW    = QW + FREQ_BITS;
	localparam int CNT_W = $clog2(QW);

	md_state_t            state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [QW-1:0]        range_q;
	logic [FREQ_BITS-1:0] factor_q;
	logic [FREQ_BITS-1:0] divisor_q;
	logic [FREQ_BITS-1:0] rem_q;
	logic [QW-1:0]        dvd_q;

	logic [FREQ_BITS:0]   trial;
	logic [FREQ_BITS:0]   diff;
	logic                 take;
	logic [FREQ_BITS-1:0] rem_next;
	logic [PW-1:0]        product;

	assign trial    = {rem_q, dvd_q[QW-1]};
	assign diff     = trial - {1'b0, divisor_q};
	assign take     = trial >= {1'b0, divisor_q};
	assign rem_next = take ? diff[FREQ_BITS-1:0] : trial[FREQ_BITS-1:0];
	assign product  = PW'(range_q) * PW'(factor_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MD_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				MD_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= MD_MUL;
					end
				end
				MD_MUL: begin
					cnt_q   <= '0;
					state_q <= MD_DIV;
				end
				MD_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QW - 1)) begin
						done_q  <= 1'b1;
						state_q <= MD_IDLE;
					end
				end
				default: begin
					state_q <= MD_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			MD_IDLE: begin
				if (start) begin
					range_q   <= range_val;
					factor_q  <= factor;
					divisor_q <= divisor;
				end
			end
			MD_MUL: begin
				rem_q <= product[PW-1:QW];
				dvd_q <= product[QW-1:0];
			end
			MD_DIV: begin
				rem_q <= rem_next;
				dvd_q <= {dvd_q[QW-2:0], take};
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	assign done     = done_q;
	assign quotient = dvd_q;

endmodule
